// ===== rtl/mts_pkg.sv =====
package mts_pkg;

    localparam int DEFAULT_STACK_DEPTH = 64;
    localparam int VALUE_W = 32;
    localparam int ENTRY_W = 34;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;

    localparam logic signed [VALUE_W-1:0] MIN_RESET = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] NONE_VALUE = -32'sd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_QUERY = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [VALUE_W-1:0] value;
    } cmd_item_t;

endpackage

// ===== rtl/mts_if.sv =====
interface mts_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [31:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink (input valid, input action, input value, output ready);
endinterface

interface mts_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] popped_value;
    logic signed [31:0] top_value;
    logic signed [31:0] min_value;
    logic               is_empty;
    logic [1:0]         status;

    modport source (
        output valid, output popped_value, output top_value, output min_value,
        output is_empty, output status, input ready
    );
    modport sink (
        input valid, input popped_value, input top_value, input min_value,
        input is_empty, input status, output ready
    );
endinterface

// ===== rtl/mts_in_reg.sv =====
module mts_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    mts_cmd_if.sink           cmd,
    input  logic              take,
    output mts_pkg::cmd_item_t item,
    output logic              item_valid
);
    import mts_pkg::*;

    logic      valid_reg;
    cmd_item_t item_reg;
    logic      accept;

    // free slot or the held item leaves this cycle
    assign cmd.ready = !valid_reg || take;
    assign accept = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.action <= cmd.action;
            item_reg.value  <= cmd.value;
        end
    end

    assign item = item_reg;
    assign item_valid = valid_reg;

endmodule

// ===== rtl/mts_core.sv =====
module mts_core #(
    parameter int STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  mts_pkg::cmd_item_t item,
    output logic               take,
    mts_rsp_if.source          rsp
);
    import mts_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // entry storage: the top entry and the one under it are also kept in registers
    logic signed [ENTRY_W-1:0] entry_mem [STACK_DEPTH];

    logic [CW-1:0]             cnt_reg, cnt_next;
    logic signed [VALUE_W-1:0] min_reg, min_next;
    logic signed [ENTRY_W-1:0] top_reg, top_next;
    logic signed [ENTRY_W-1:0] under_reg;

    logic                      wr_en;
    logic signed [ENTRY_W-1:0] wr_entry;
    logic [AW-1:0]             wr_addr;
    logic [AW-1:0]             rd_addr;
    logic                      under_load;
    logic                      under_from_mem;

    logic signed [ENTRY_W-1:0] val_ext;
    logic signed [ENTRY_W-1:0] min_ext;
    logic signed [ENTRY_W-1:0] min_next_ext;
    logic signed [ENTRY_W-1:0] restored_min;

    logic signed [VALUE_W-1:0] popped_next, top_val_next, min_val_next;
    logic                      empty_next;
    status_t                   status_next;

    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] popped_reg, top_val_reg, min_val_reg;
    logic                      empty_reg;
    status_t                   status_reg;

    assign take = item_valid && (!out_valid_reg || rsp.ready);

    assign val_ext = ENTRY_W'(item.value);
    assign min_ext = ENTRY_W'(min_reg);
    assign restored_min = (min_ext <<< 1) - top_reg;
    assign wr_addr = cnt_reg[AW-1:0];
    // entry two below the current top becomes the new under entry on pop
    assign rd_addr = AW'(cnt_reg - CW'(3));

    always_comb
    begin
        cnt_next       = cnt_reg;
        min_next       = min_reg;
        top_next       = top_reg;
        popped_next    = NONE_VALUE;
        status_next    = ST_OK;
        wr_en          = 1'b0;
        wr_entry       = val_ext;
        under_load     = 1'b0;
        under_from_mem = 1'b0;

        case (action_t'(item.action))
            ACT_PUSH:
            begin
                if (cnt_reg == CW'(STACK_DEPTH))
                begin
                    status_next = ST_PUSH_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    under_load = 1'b1;
                    cnt_next   = cnt_reg + CW'(1);
                    if (cnt_reg == '0)
                    begin
                        min_next = item.value;
                    end
                    else if (item.value < min_reg)
                    begin
                        // encoded entry sits below the new minimum
                        wr_entry = (val_ext <<< 1) - min_ext;
                        min_next = item.value;
                    end
                    top_next = wr_entry;
                end
            end
            ACT_POP:
            begin
                if (cnt_reg == '0)
                begin
                    status_next = ST_POP_EMPTY;
                end
                else
                begin
                    cnt_next       = cnt_reg - CW'(1);
                    top_next       = under_reg;
                    under_load     = 1'b1;
                    under_from_mem = 1'b1;
                    if (top_reg > min_ext)
                    begin
                        popped_next = top_reg[VALUE_W-1:0];
                    end
                    else
                    begin
                        popped_next = min_reg;
                        min_next    = restored_min[VALUE_W-1:0];
                    end
                end
            end
            default:
            begin
                // query and unused code leave the stack alone
            end
        endcase
    end

    assign min_next_ext = ENTRY_W'(min_next);

    always_comb
    begin
        empty_next   = (cnt_next == '0);
        top_val_next = NONE_VALUE;
        min_val_next = NONE_VALUE;
        if (!empty_next)
        begin
            min_val_next = min_next;
            if (top_next < min_next_ext)
            begin
                top_val_next = min_next;
            end
            else
            begin
                top_val_next = top_next[VALUE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            min_reg       <= MIN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                cnt_reg       <= cnt_next;
                min_reg       <= min_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            top_reg     <= top_next;
            popped_reg  <= popped_next;
            top_val_reg <= top_val_next;
            min_val_reg <= min_val_next;
            empty_reg   <= empty_next;
            status_reg  <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && wr_en)
        begin
            entry_mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && under_load)
        begin
            if (under_from_mem)
            begin
                under_reg <= entry_mem[rd_addr];
            end
            else
            begin
                under_reg <= top_reg;
            end
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.popped_value = popped_reg;
    assign rsp.top_value    = top_val_reg;
    assign rsp.min_value    = min_val_reg;
    assign rsp.is_empty     = empty_reg;
    assign rsp.status       = status_reg;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(STACK_DEPTH))
        else $error("entry count beyond stack depth");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (empty_reg == (cnt_reg == '0)))
        else $error("empty flag disagrees with entry count");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_PUSH_FULL) |-> (cnt_reg == CW'(STACK_DEPTH)))
        else $error("push refused while not full");

    a_min_le_top: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !empty_reg) |-> (min_val_reg <= top_val_reg))
        else $error("minimum above top value");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (take && item.action == ACT_POP && cnt_reg != '0)
            |=> (cnt_reg == $past(cnt_reg) - CW'(1)))
        else $error("pop did not remove one entry");
`endif

endmodule

// ===== rtl/min_tracking_stack_top.sv =====
// channel | dir | handshake   | payload
// cmd     | in  | valid/ready | action[1:0], value[31:0] signed
// rsp     | out | valid/ready | popped_value, top_value, min_value (32 signed),
//         |     |             | is_empty, status[1:0]
//
// one item per cycle sustained while rsp is ready; an accepted item is held in the
// input register, then its result loads into the result register; the input register
// and the result register sit around the stack update
// reset clears the entry count and loads the running minimum with the largest
// positive value; entry storage is not cleared and needs no sweep
// a stalled rsp holds the result register; cmd still fills the free input slot
module min_tracking_stack_top #(
    parameter int STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    mts_cmd_if.sink   cmd,
    mts_rsp_if.source rsp
);
    import mts_pkg::*;

    // registered item handed from the input slot to the stack core
    cmd_item_t item;
    logic      item_valid;
    // core consumes the held item this cycle
    logic      take;

    mts_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .take       (take),
        .item       (item),
        .item_valid (item_valid)
    );

    // stack state, entry memory and result register
    mts_core #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .rsp        (rsp)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// checks the min tracking stack item by item against an in-bench stack model
// that holds the same 34-bit encoded entries
module tb;
    import mts_pkg::*;

    localparam int STACK_DEPTH = DEFAULT_STACK_DEPTH;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam logic signed [VALUE_W-1:0] VALUE_LO = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_HI = 32'sh7FFF_FFFF;
    // the one action code that the package leaves unnamed, behaves as a query
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic signed [VALUE_W-1:0] popped_value;
        logic signed [VALUE_W-1:0] top_value;
        logic signed [VALUE_W-1:0] min_value;
        logic                      is_empty;
        status_t                   status;
    } stack_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mts_cmd_if cmd_ch ();
    mts_rsp_if rsp_ch ();

    min_tracking_stack_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always #4 clk = ~clk;

    // model of the stack: encoded entries, entry count, running minimum
    logic signed [ENTRY_W-1:0] model_entries [STACK_DEPTH];
    int                        model_count;
    logic signed [VALUE_W-1:0] model_min;

    // items waiting to be driven, results waiting to come out
    cmd_item_t     pending_q [$];
    stack_result_t expected_q [$];
    cmd_item_t     next_item;

    // traffic shaping, set by the stimulus thread
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_off = 1'b0;
    logic item_held = 1'b0;

    int error_count = 0;
    int cycle_count = 0;

    // one line per mismatch, counted
    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    // apply one item to the model stack and return the result it should give
    function automatic stack_result_t apply_stack_op(logic [ACTION_W-1:0] act,
                                                     logic signed [VALUE_W-1:0] val);
        stack_result_t r;
        longint v;
        longint m;
        longint cur;
        v = val;
        m = model_min;
        r.popped_value = NONE_VALUE;
        r.status = ST_OK;
        case (act)
            ACT_PUSH:
            begin
                if (model_count >= STACK_DEPTH)
                begin
                    r.status = ST_PUSH_FULL;
                end
                else if (model_count == 0)
                begin
                    model_entries[0] = ENTRY_W'(v);
                    model_min = val;
                    model_count = 1;
                end
                else if (v < m)
                begin
                    // new minimum: store an entry below it that encodes the old one
                    model_entries[model_count] = ENTRY_W'(2 * v - m);
                    model_min = val;
                    model_count++;
                end
                else
                begin
                    model_entries[model_count] = ENTRY_W'(v);
                    model_count++;
                end
            end
            ACT_POP:
            begin
                if (model_count == 0)
                begin
                    r.status = ST_POP_EMPTY;
                end
                else
                begin
                    cur = model_entries[model_count - 1];
                    model_count--;
                    if (cur > m)
                    begin
                        r.popped_value = VALUE_W'(cur);
                    end
                    else
                    begin
                        // encoded entry: the minimum leaves, the old one comes back
                        r.popped_value = model_min;
                        model_min = VALUE_W'(2 * m - cur);
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.is_empty = (model_count == 0);
        r.top_value = NONE_VALUE;
        r.min_value = NONE_VALUE;
        if (model_count > 0)
        begin
            cur = model_entries[model_count - 1];
            m = model_min;
            r.top_value = (cur < m) ? model_min : VALUE_W'(cur);
            r.min_value = model_min;
        end
        return r;
    endfunction

    task automatic add_item(logic [ACTION_W-1:0] act, logic signed [VALUE_W-1:0] val);
        cmd_item_t c;
        c.action = act;
        c.value = val;
        pending_q.insert(pending_q.size(), c);
    endtask

    // values lean on the extremes and on a small band so that equal minimums recur
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: return VALUE_LO;
            1: return VALUE_HI;
            2, 3, 4: return $urandom_range(40) - 20;
            default: return $urandom;
        endcase
    endfunction

    // a run of pushes, either random or falling so most of them set a new minimum
    task automatic add_push_run(int n);
        longint v;
        longint step;
        logic falling;
        falling = 1'($urandom_range(1));
        v = pick_value();
        step = $urandom_range(5000, 1);
        for (int i = 0; i < n; i++)
        begin
            add_item(ACT_PUSH, falling ? VALUE_W'(v) : pick_value());
            v = v - step;
            if (v < VALUE_LO)
            begin
                v = VALUE_LO;
            end
        end
    endtask

    task automatic add_pop_run(int n);
        for (int i = 0; i < n; i++)
        begin
            add_item(ACT_POP, $urandom);
        end
    endtask

    // random segments: mixed traffic, long push runs that can reach full, long pop runs
    task automatic add_random_items(int n);
        int added;
        int kind;
        int k;
        int r;
        added = 0;
        while (added < n)
        begin
            kind = $urandom_range(9);
            if (kind < 2)
            begin
                k = $urandom_range(STACK_DEPTH + 4, 1);
                add_push_run(k);
            end
            else if (kind == 2)
            begin
                k = $urandom_range(STACK_DEPTH + 4, 1);
                add_pop_run(k);
            end
            else
            begin
                k = $urandom_range(20, 4);
                for (int i = 0; i < k; i++)
                begin
                    r = $urandom_range(99);
                    if (r < 45) add_item(ACT_PUSH, pick_value());
                    else if (r < 80) add_item(ACT_POP, $urandom);
                    else if (r < 95) add_item(ACT_QUERY, $urandom);
                    else add_item(ACT_UNUSED, $urandom);
                end
            end
            added += k;
        end
    endtask

    task automatic wait_all_sent();
        while (pending_q.size() > 0 || item_held) @(posedge clk);
    endtask

    // driver: new items go out at the falling edge, a held item stays until taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            if (!item_held)
            begin
                if (pending_q.size() > 0 && !hold_off
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item = pending_q.pop_front();
                    cmd_ch.valid <= 1'b1;
                    cmd_ch.action <= next_item.action;
                    cmd_ch.value <= next_item.value;
                    item_held = 1'b1;
                end
                else
                begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: accepted items feed the model, accepted results are checked in order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                expected_q.insert(expected_q.size(),
                                  apply_stack_op(cmd_ch.action, cmd_ch.value));
                item_held = 1'b0;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch("result with nothing pending, popped_value",
                                    rsp_ch.popped_value, 0);
                end
                else
                begin
                    stack_result_t want;
                    want = expected_q.pop_front();
                    if (rsp_ch.popped_value !== want.popped_value)
                        report_mismatch("popped_value", rsp_ch.popped_value,
                                        want.popped_value);
                    if (rsp_ch.top_value !== want.top_value)
                        report_mismatch("top_value", rsp_ch.top_value, want.top_value);
                    if (rsp_ch.min_value !== want.min_value)
                        report_mismatch("min_value", rsp_ch.min_value, want.min_value);
                    if (rsp_ch.is_empty !== want.is_empty)
                        report_mismatch("is_empty", rsp_ch.is_empty, want.is_empty);
                    if (rsp_ch.status !== want.status)
                        report_mismatch("status", rsp_ch.status, want.status);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        cmd_ch.valid = 1'b0;
        cmd_ch.action = ACT_QUERY;
        cmd_ch.value = '0;
        rsp_ch.ready = 1'b0;
        model_count = 0;
        model_min = MIN_RESET;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty stack, extremes, equal minimums, encoded entries
        add_item(ACT_QUERY, 32'sd5);
        add_item(ACT_POP, 32'sd0);
        add_item(ACT_UNUSED, VALUE_HI);
        add_item(ACT_PUSH, VALUE_HI);
        add_item(ACT_PUSH, VALUE_HI);
        // largest possible gap, the encoded entry needs all 34 bits
        add_item(ACT_PUSH, VALUE_LO);
        add_item(ACT_PUSH, VALUE_LO);
        add_item(ACT_QUERY, VALUE_LO);
        add_item(ACT_PUSH, 32'sd0);
        add_item(ACT_UNUSED, -32'sd1);
        add_pop_run(6);
        add_item(ACT_PUSH, -32'sd1);
        add_item(ACT_PUSH, -32'sd5);
        add_item(ACT_PUSH, 32'sd7);
        add_item(ACT_PUSH, -32'sd5);
        add_pop_run(5);

        // fill to the top, push twice into a full stack, then empty it again
        for (int i = 0; i < STACK_DEPTH + 2; i++)
        begin
            add_item(ACT_PUSH, pick_value());
        end
        add_pop_run(STACK_DEPTH + 2);

        // no idling
        add_random_items(80);
        wait_all_sent();

        // sender idle most of the time, with one pause until every result is back
        send_idle_pct = 63;
        recv_stall_pct = 0;
        add_random_items(90);
        while (pending_q.size() > 60) @(posedge clk);
        hold_off = 1'b1;
        while (item_held || expected_q.size() > 0) @(posedge clk);
        hold_off = 1'b0;
        wait_all_sent();

        // receiver stalling most of the time
        send_idle_pct = 0;
        recv_stall_pct = 63;
        add_random_items(90);
        wait_all_sent();

        // both sides idling now and then
        send_idle_pct = 24;
        recv_stall_pct = 24;
        add_random_items(90);
        wait_all_sent();

        while (expected_q.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_q.size() > 0)
        begin
            report_mismatch("results missing at end, count", expected_q.size(), 0);
        end

        if (error_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/mts_pkg.sv
rtl/mts_if.sv
rtl/mts_in_reg.sv
rtl/mts_core.sv
rtl/min_tracking_stack_top.sv
tb/tb.sv
